### sv/hle_pkg.sv
// Shared types, constants and helpers for the heartbeat leader election block.
`default_nettype none
package hle_pkg;

	localparam int ADDR_BITS  = 32;
	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = 16;
	localparam int CMP_BITS   = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 2;
	localparam int PADDR_BITS = 4;
	localparam int PDATA_BITS = 32;
	localparam int OQ_DEPTH   = 4;
	localparam int OQ_PTR     = $clog2(OQ_DEPTH);

	localparam logic [CMP_BITS-1:0] CNT_MAX_C = CMP_BITS'((64'd1 << COUNT_BITS) - 64'd1);

	localparam logic [CFG_BITS-1:0] HB_RESET   = CFG_BITS'(2000);
	localparam logic [CFG_BITS-1:0] LAT_RESET  = CFG_BITS'(1000);
	localparam logic [CFG_BITS-1:0] RESP_RESET = CFG_BITS'(2000);

	typedef enum logic [1:0] {
		REG_HEARTBEAT = 2'd0,
		REG_LATENCY   = 2'd1,
		REG_RESPONSE  = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_PACKET = 2'd1,
		CMD_START  = 2'd2,
		CMD_STOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ROLE_SLAVE  = 2'd0,
		ROLE_CAND   = 2'd1,
		ROLE_MASTER = 2'd2,
		ROLE_RSVD   = 2'd3
	} role_t;

	localparam logic [3:0] T_CANDUP    = 4'd1;
	localparam logic [3:0] T_HANDOVER  = 4'd2;
	localparam logic [3:0] T_MHB       = 4'd3;
	localparam logic [3:0] T_MUP       = 4'd4;
	localparam logic [3:0] T_STANDDOWN = 4'd5;
	localparam logic [3:0] T_SHB       = 4'd6;
	localparam logic [3:0] T_SUP       = 4'd7;
	localparam logic [3:0] T_QUERY     = 4'd8;
	localparam logic [3:0] T_NODEUP    = 4'd9;
	localparam logic [3:0] T_NODEDOWN  = 4'd10;

	localparam logic [1:0] DEST_BCAST  = 2'd0;
	localparam logic [1:0] DEST_SENDER = 2'd1;
	localparam logic [1:0] DEST_SLAVE  = 2'd2;

	typedef struct packed {
		logic [CFG_BITS-1:0] heartbeat_ms;
		logic [CFG_BITS-1:0] lat_tol_ms;
		logic [CFG_BITS-1:0] resp_wait_ms;
	} cfg_t;

	typedef struct packed {
		logic [3:0]           send_type;
		logic [1:0]           dest_kind;
		logic [ADDR_BITS-1:0] dest_addr;
		logic [1:0]           role_now;
		logic                 last;
	} res_t;

	function automatic res_t make_res(logic [3:0] t, logic [1:0] k, logic [ADDR_BITS-1:0] a);
		res_t r;
		r.send_type = t;
		r.dest_kind = k;
		r.dest_addr = (k == DEST_BCAST) ? '0 : a;
		r.role_now  = ROLE_SLAVE;
		r.last      = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/hle_regs.sv
// APB-style configuration registers.
`default_nettype none
module hle_regs
	import hle_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic      [PDATA_BITS-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heartbeat_ms <= HB_RESET;
			cfg_q.lat_tol_ms   <= LAT_RESET;
			cfg_q.resp_wait_ms <= RESP_RESET;
		end else if (wr) begin
			case (idx)
				REG_HEARTBEAT: cfg_q.heartbeat_ms <= pwdata[CFG_BITS-1:0];
				REG_LATENCY:   cfg_q.lat_tol_ms   <= pwdata[CFG_BITS-1:0];
				REG_RESPONSE:  cfg_q.resp_wait_ms <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HEARTBEAT: prdata = PDATA_BITS'(cfg_q.heartbeat_ms);
			REG_LATENCY:   prdata = PDATA_BITS'(cfg_q.lat_tol_ms);
			REG_RESPONSE:  prdata = PDATA_BITS'(cfg_q.resp_wait_ms);
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### sv/hle_engine.sv
// Input register, election state and the per-request decision logic.
`default_nettype none
module hle_engine
	import hle_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  cfg_t                      cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           cmd,
	input  wire logic [3:0]           msg_type,
	input  wire logic [ADDR_BITS-1:0] sender_addr,
	input  wire logic [9:0]           random_ms,
	input  wire logic                 room,
	output logic                      push,
	output logic [1:0]                push_n,
	output res_t                      res0,
	output res_t                      res1
);

	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic [3:0]           type_s1;
	logic [ADDR_BITS-1:0] from_s1;
	logic [9:0]           rnd_s1;
	logic                 advance;

	// election state
	logic                  running_q, armed_q, seen_q, slave_valid_q;
	role_t                 role_q;
	logic [COUNT_BITS-1:0] hbc_q, mwc_q, period_q, since_q;
	logic [ADDR_BITS-1:0]  slave_addr_q;

	logic                  running_d, armed_d, seen_d, slave_valid_d;
	role_t                 role_d;
	logic [COUNT_BITS-1:0] hbc_d, mwc_d, period_d, since_d;
	logic [ADDR_BITS-1:0]  slave_addr_d;

	logic [CMP_BITS-1:0]   wp_sum, hbc_inc, mwc_inc, lim;
	logic [COUNT_BITS-1:0] wp;
	res_t                  r [2];
	logic [1:0]            nres;
	role_t                 role_pre;

	assign advance  = valid_s1 & room;
	assign in_ready = ~valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd_t'(cmd);
			type_s1 <= msg_type;
			from_s1 <= sender_addr;
			rnd_s1  <= random_ms;
		end
	end

	// master wait period, saturated at the counter's top
	assign wp_sum = CMP_BITS'(cfg.heartbeat_ms) + CMP_BITS'(cfg.lat_tol_ms) + CMP_BITS'(rnd_s1);
	assign wp     = (wp_sum > CNT_MAX_C) ? {COUNT_BITS{1'b1}} : wp_sum[COUNT_BITS-1:0];

	assign hbc_inc = (CMP_BITS'(hbc_q) < CNT_MAX_C) ? CMP_BITS'(hbc_q) + 1'b1 : CMP_BITS'(hbc_q);
	assign mwc_inc = (CMP_BITS'(mwc_q) < CNT_MAX_C) ? CMP_BITS'(mwc_q) + 1'b1 : CMP_BITS'(mwc_q);
	assign lim     = (role_q == ROLE_CAND) ? CMP_BITS'(cfg.resp_wait_ms) : CMP_BITS'(period_q);

	always_comb begin
		running_d     = running_q;
		armed_d       = armed_q;
		seen_d        = seen_q;
		slave_valid_d = slave_valid_q;
		role_d        = role_q;
		hbc_d         = hbc_q;
		mwc_d         = mwc_q;
		period_d      = period_q;
		since_d       = since_q;
		slave_addr_d  = slave_addr_q;
		r[0]          = make_res(T_SUP, DEST_BCAST, '0);
		r[1]          = make_res(T_SUP, DEST_BCAST, '0);
		nres          = 2'd0;
		role_pre      = role_q;

		case (cmd_s1)
			CMD_START: begin
				if (!running_q) begin
					running_d     = 1'b1;
					role_d        = ROLE_SLAVE;
					hbc_d         = '0;
					mwc_d         = '0;
					period_d      = wp;
					armed_d       = 1'b1;
					seen_d        = 1'b0;
					since_d       = '0;
					slave_addr_d  = '0;
					slave_valid_d = 1'b0;
					r[0]          = make_res(T_SUP, DEST_BCAST, '0);
					r[1]          = make_res(T_QUERY, DEST_BCAST, '0);
					nres          = 2'd2;
				end
			end
			CMD_STOP: begin
				if (running_q) begin
					if (role_q == ROLE_MASTER && slave_valid_q) begin
						r[0] = make_res(T_HANDOVER, DEST_SLAVE, slave_addr_q);
						r[1] = make_res(T_NODEDOWN, DEST_BCAST, '0);
						nres = 2'd2;
					end else begin
						r[0] = make_res(T_NODEDOWN, DEST_BCAST, '0);
						nres = 2'd1;
					end
					running_d     = 1'b0;
					role_d        = ROLE_SLAVE;
					hbc_d         = '0;
					mwc_d         = '0;
					period_d      = '0;
					armed_d       = 1'b0;
					seen_d        = 1'b0;
					since_d       = '0;
					slave_addr_d  = '0;
					slave_valid_d = 1'b0;
				end
			end
			CMD_TICK: begin
				if (running_q) begin
					if (since_q != {COUNT_BITS{1'b1}}) since_d = since_q + 1'b1;
					hbc_d = hbc_inc[COUNT_BITS-1:0];
					// heartbeat result goes first when both timers fire
					if (hbc_inc >= CMP_BITS'(cfg.heartbeat_ms)) begin
						hbc_d = '0;
						r[0]  = make_res((role_q == ROLE_MASTER) ? T_MHB : T_SHB,
							DEST_BCAST, '0);
						nres  = 2'd1;
					end
					if (armed_q) begin
						mwc_d = mwc_inc[COUNT_BITS-1:0];
						if (mwc_inc >= lim) begin
							mwc_d = '0;
							if (role_q == ROLE_CAND) begin
								role_d   = ROLE_MASTER;
								armed_d  = 1'b0;
								r[nres[0]] = make_res(T_MUP, DEST_BCAST, '0);
							end else begin
								role_d   = ROLE_CAND;
								r[nres[0]] = make_res(T_CANDUP, DEST_BCAST, '0);
							end
							nres = nres + 2'd1;
						end
					end
				end
			end
			default: begin
				// received packet
				if (running_q) begin
					if (type_s1 == T_HANDOVER) begin
						if (role_q != ROLE_MASTER) begin
							role_d = ROLE_MASTER;
							r[0]   = make_res(T_MUP, DEST_BCAST, '0);
							nres   = 2'd1;
						end
					end else if (type_s1 == T_SHB || type_s1 == T_SUP) begin
						slave_addr_d  = from_s1;
						slave_valid_d = 1'b1;
					end else if (type_s1 == T_QUERY || type_s1 == T_NODEUP) begin
						r[0] = make_res((role_q == ROLE_MASTER) ? T_MUP :
							(role_q == ROLE_CAND) ? T_CANDUP : T_SUP,
							DEST_SENDER, from_s1);
						nres = 2'd1;
					end else begin
						if (type_s1 == T_MHB || type_s1 == T_MUP) begin
							seen_d  = 1'b1;
							since_d = '0;
							mwc_d   = '0;
							armed_d = 1'b1;
						end
						if (role_pre == ROLE_CAND) begin
							if (type_s1 == T_CANDUP) begin
								r[0] = make_res(T_STANDDOWN, DEST_SENDER, from_s1);
								nres = 2'd1;
							end else if (type_s1 == T_MHB || type_s1 == T_MUP ||
									type_s1 == T_STANDDOWN) begin
								role_d   = ROLE_SLAVE;
								period_d = wp;
								mwc_d    = '0;
								armed_d  = 1'b1;
								r[0]     = make_res(T_SUP, DEST_BCAST, '0);
								nres     = 2'd1;
							end
						end else if (role_pre == ROLE_MASTER) begin
							if (type_s1 == T_CANDUP || type_s1 == T_MHB || type_s1 == T_MUP) begin
								r[0] = make_res(T_STANDDOWN, DEST_SENDER, from_s1);
								nres = 2'd1;
							end else if (type_s1 == T_STANDDOWN) begin
								role_d   = ROLE_SLAVE;
								period_d = wp;
								mwc_d    = '0;
								armed_d  = 1'b1;
								r[0]     = make_res(T_SUP, DEST_BCAST, '0);
								nres     = 2'd1;
							end
						end else begin
							if (type_s1 == T_CANDUP && seen_q &&
									CMP_BITS'(since_q) < CMP_BITS'(cfg.heartbeat_ms)) begin
								r[0] = make_res(T_STANDDOWN, DEST_SENDER, from_s1);
								nres = 2'd1;
							end
						end
					end
				end
			end
		endcase

		r[0].role_now = role_d;
		r[1].role_now = role_d;
		r[0].last     = (nres == 2'd1);
		r[1].last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			armed_q       <= 1'b0;
			seen_q        <= 1'b0;
			slave_valid_q <= 1'b0;
			role_q        <= ROLE_SLAVE;
			hbc_q         <= '0;
			mwc_q         <= '0;
			period_q      <= '0;
			since_q       <= '0;
			slave_addr_q  <= '0;
		end else if (advance) begin
			running_q     <= running_d;
			armed_q       <= armed_d;
			seen_q        <= seen_d;
			slave_valid_q <= slave_valid_d;
			role_q        <= role_d;
			hbc_q         <= hbc_d;
			mwc_q         <= mwc_d;
			period_q      <= period_d;
			since_q       <= since_d;
			slave_addr_q  <= slave_addr_d;
		end
	end

	assign push   = advance && (nres != 2'd0);
	assign push_n = nres;
	assign res0   = r[0];
	assign res1   = r[1];

endmodule
`default_nettype wire

### sv/hle_outq.sv
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none
module hle_outq
	import hle_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [1:0] push_n,
	input  res_t            res0,
	input  res_t            res1,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_t            head
);

	res_t              mem [OQ_DEPTH];
	logic [OQ_PTR-1:0] wr_q, rd_q;
	logic [OQ_PTR:0]   cnt_q;
	logic              pop;
	logic [OQ_PTR:0]   add;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign room      = (cnt_q <= (OQ_PTR+1)'(OQ_DEPTH - 2));
	assign head      = mem[rd_q];
	assign add       = push ? (OQ_PTR+1)'(push_n) : '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= res0;
			if (push_n == 2'd2) mem[wr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + add[OQ_PTR-1:0];
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + add - (OQ_PTR+1)'(pop);
		end
	end

endmodule
`default_nettype wire

### sv/heartbeat_leader_election.sv
// Top level of the heartbeat leader election engine.
//
//  channel  | handshake                    | carries
//  ---------+------------------------------+------------------------------------------
//  input    | in_valid / in_ready          | cmd, msg_type, sender_addr, random_ms
//  output   | out_valid / out_ready        | send_type, dest_kind, dest_addr, role_now, last
//  config   | psel/penable/pwrite, pready  | paddr, pwdata, prdata (3 regs at 0x0/0x4/0x8)
//
// A request is registered on acceptance and decided from that register: one request
// per cycle, limited by the single decision stage and the 4-entry result queue,
// which must have room for two results before the stage retires a request.
// Requests that cause two results can stall the input when the output drains one
// result per cycle. Results pass through the result queue's registers to the output.
// arst_n clears the election state and the queue; registers return to 2000/1000/2000.
`default_nettype none
module heartbeat_leader_election
	import hle_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic      [PDATA_BITS-1:0] prdata,
	output logic                       pready,
	// request channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            cmd,
	input  wire logic [3:0]            msg_type,
	input  wire logic [ADDR_BITS-1:0]  sender_addr,
	input  wire logic [9:0]            random_ms,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [3:0]            send_type,
	output logic      [1:0]            dest_kind,
	output logic      [ADDR_BITS-1:0]  dest_addr,
	output logic      [1:0]            role_now,
	output logic                       last
);

	cfg_t       cfg;
	logic       room, push;
	logic [1:0] push_n;
	res_t       res0, res1, head;

	hle_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// decision stage: input register plus election state
	hle_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.msg_type   (msg_type),
		.sender_addr(sender_addr),
		.random_ms  (random_ms),
		.room       (room),
		.push       (push),
		.push_n     (push_n),
		.res0       (res0),
		.res1       (res1)
	);

	// results wait here so the decision stage keeps moving
	hle_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_n   (push_n),
		.res0     (res0),
		.res1     (res1),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign send_type = head.send_type;
	assign dest_kind = head.dest_kind;
	assign dest_addr = head.dest_addr;
	assign role_now  = head.role_now;
	assign last      = head.last;

endmodule
`default_nettype wire

### tb/tb_heartbeat_leader_election.sv
// Self-checking testbench for the heartbeat leader election engine.
module tb_heartbeat_leader_election;
	timeunit 1ns;
	timeprecision 1ps;

	import hle_pkg::*;

	// Guard against a hung run: far above the slowest correct run, with every
	// request causing two results under the longest output stalls.
	localparam int CYCLE_LIMIT = 100_000;
	localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

	// One node event as presented on the request channel.
	typedef struct packed {
		cmd_t                 cmd;
		logic [3:0]           msg_type;
		logic [ADDR_BITS-1:0] sender;
		logic [9:0]           rnd;
	} node_evt_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [PADDR_BITS-1:0] paddr       = '0;
	logic [PDATA_BITS-1:0] pwdata      = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [1:0]            cmd         = '0;
	logic [3:0]            msg_type    = '0;
	logic [ADDR_BITS-1:0]  sender_addr = '0;
	logic [9:0]            random_ms   = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [3:0]            send_type;
	logic [1:0]            dest_kind;
	logic [ADDR_BITS-1:0]  dest_addr;
	logic [1:0]            role_now;
	logic                  last;

	heartbeat_leader_election u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.msg_type    (msg_type),
		.sender_addr (sender_addr),
		.random_ms   (random_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.send_type   (send_type),
		.dest_kind   (dest_kind),
		.dest_addr   (dest_addr),
		.role_now    (role_now),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Election model: our own copy of the registers and node state.
	// ------------------------------------------------------------------
	logic [CFG_BITS-1:0]   hb_ms   = 16'd2000;
	logic [CFG_BITS-1:0]   lat_ms  = 16'd1000;
	logic [CFG_BITS-1:0]   resp_ms = 16'd2000;

	logic                  el_run      = 1'b0;
	role_t                 el_role     = ROLE_SLAVE;
	logic [COUNT_BITS-1:0] el_hb_cnt   = '0;
	logic [COUNT_BITS-1:0] el_wait_cnt = '0;
	logic [COUNT_BITS-1:0] el_wait_len = '0;
	logic                  el_wait_on  = 1'b0;
	logic                  el_seen     = 1'b0;
	logic [COUNT_BITS-1:0] el_since    = '0;
	logic [ADDR_BITS-1:0]  el_slave    = '0;
	logic                  el_slave_ok = 1'b0;

	res_t      step_out[$];       // sends caused by the request being modeled
	res_t      pending_sends[$];  // sends predicted but not yet seen on the output
	node_evt_t evt_backlog[$];    // requests waiting for the driver
	int        evts_queued = 0;
	int        evts_done   = 0;
	int        mismatches  = 0;
	logic      calm        = 1'b0;  // no idling on either side while set

	// Master wait period: heartbeat + latency + draw, clipped to the counter.
	function automatic logic [COUNT_BITS-1:0] wait_len(logic [9:0] rnd);
		int unsigned sum;
		sum = int'(hb_ms) + int'(lat_ms) + int'(rnd);
		return (sum > int'(CNT_TOP)) ? CNT_TOP : COUNT_BITS'(sum);
	endfunction

	// At most two sends per request; broadcast carries a zero address.
	function automatic void send_msg(logic [3:0] mtype, logic [1:0] dk,
			logic [ADDR_BITS-1:0] da);
		res_t s;
		if (step_out.size() < 2) begin
			s.send_type = mtype;
			s.dest_kind = dk;
			s.dest_addr = (dk == DEST_BCAST) ? '0 : da;
			s.role_now  = ROLE_SLAVE;
			s.last      = 1'b0;
			step_out.push_back(s);
		end
	endfunction

	function automatic void clear_election();
		el_run      = 1'b0;
		el_role     = ROLE_SLAVE;
		el_hb_cnt   = '0;
		el_wait_cnt = '0;
		el_wait_len = '0;
		el_wait_on  = 1'b0;
		el_seen     = 1'b0;
		el_since    = '0;
		el_slave    = '0;
		el_slave_ok = 1'b0;
	endfunction

	function automatic void demote(logic [9:0] rnd);
		el_role     = ROLE_SLAVE;
		el_wait_len = wait_len(rnd);
		el_wait_cnt = '0;
		el_wait_on  = 1'b1;
		send_msg(T_SUP, DEST_BCAST, '0);
	endfunction

	// Advance the model by one accepted request and queue the sends it causes.
	function automatic void elect_step(node_evt_t ev);
		logic [COUNT_BITS-1:0] lim;
		logic                  role_rules;
		logic [3:0]            up_msg;
		step_out.delete();
		role_rules = 1'b1;
		case (ev.cmd)
			CMD_START: if (!el_run) begin
				clear_election();
				el_run      = 1'b1;
				el_wait_len = wait_len(ev.rnd);
				el_wait_on  = 1'b1;
				send_msg(T_SUP, DEST_BCAST, '0);
				send_msg(T_QUERY, DEST_BCAST, '0);
			end
			CMD_STOP: if (el_run) begin
				if (el_role == ROLE_MASTER && el_slave_ok)
					send_msg(T_HANDOVER, DEST_SLAVE, el_slave);
				send_msg(T_NODEDOWN, DEST_BCAST, '0);
				clear_election();
			end
			CMD_TICK: if (el_run) begin
				if (el_since < CNT_TOP)
					el_since++;
				if (el_hb_cnt < CNT_TOP)
					el_hb_cnt++;
				// heartbeat goes out before any timer result on the same tick
				if (el_hb_cnt >= hb_ms) begin
					el_hb_cnt = '0;
					send_msg((el_role == ROLE_MASTER) ? T_MHB : T_SHB, DEST_BCAST, '0);
				end
				if (el_wait_on) begin
					lim = (el_role == ROLE_CAND) ? resp_ms : el_wait_len;
					if (el_wait_cnt < CNT_TOP)
						el_wait_cnt++;
					if (el_wait_cnt >= lim) begin
						el_wait_cnt = '0;
						if (el_role == ROLE_CAND) begin
							el_role    = ROLE_MASTER;
							el_wait_on = 1'b0;
							send_msg(T_MUP, DEST_BCAST, '0);
						end else begin
							el_role = ROLE_CAND;
							send_msg(T_CANDUP, DEST_BCAST, '0);
						end
					end
				end
			end
			CMD_PACKET: if (el_run) begin
				case (ev.msg_type)
					T_HANDOVER: begin
						role_rules = 1'b0;
						if (el_role != ROLE_MASTER) begin
							el_role = ROLE_MASTER;
							send_msg(T_MUP, DEST_BCAST, '0);
						end
					end
					T_SHB, T_SUP: begin
						role_rules  = 1'b0;
						el_slave    = ev.sender;
						el_slave_ok = 1'b1;
					end
					T_MHB, T_MUP: begin
						el_seen     = 1'b1;
						el_since    = '0;
						el_wait_cnt = '0;
						el_wait_on  = 1'b1;
					end
					T_QUERY, T_NODEUP: begin
						role_rules = 1'b0;
						if (el_role == ROLE_MASTER)
							up_msg = T_MUP;
						else if (el_role == ROLE_CAND)
							up_msg = T_CANDUP;
						else
							up_msg = T_SUP;
						send_msg(up_msg, DEST_SENDER, ev.sender);
					end
					default: ;
				endcase
				if (role_rules) begin
					if (el_role == ROLE_CAND) begin
						if (ev.msg_type == T_CANDUP)
							send_msg(T_STANDDOWN, DEST_SENDER, ev.sender);
						else if (ev.msg_type == T_MHB || ev.msg_type == T_MUP ||
								ev.msg_type == T_STANDDOWN)
							demote(ev.rnd);
					end else if (el_role == ROLE_MASTER) begin
						if (ev.msg_type == T_CANDUP || ev.msg_type == T_MHB ||
								ev.msg_type == T_MUP)
							send_msg(T_STANDDOWN, DEST_SENDER, ev.sender);
						else if (ev.msg_type == T_STANDDOWN)
							demote(ev.rnd);
					end else begin
						// a slave defends a master it heard within one heartbeat
						if (ev.msg_type == T_CANDUP && el_seen && el_since < hb_ms)
							send_msg(T_STANDDOWN, DEST_SENDER, ev.sender);
					end
				end
			end
			default: ;
		endcase
		foreach (step_out[i]) begin
			step_out[i].role_now = el_role;
			step_out[i].last     = (i == step_out.size() - 1);
			pending_sends.push_back(step_out[i]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request driver: presents the backlog, idling now and then.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : driver
		node_evt_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				elect_step({cmd_t'(cmd), msg_type, sender_addr, random_ms});
				evts_done++;
			end
			// the slot is free when nothing was held or the held request just went
			if (!in_valid || in_ready) begin
				if (evt_backlog.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
					nxt = evt_backlog.pop_front();
					cmd         <= nxt.cmd;
					msg_type    <= nxt.msg_type;
					sender_addr <= nxt.sender;
					random_ms   <= nxt.rnd;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: every accepted send against the oldest prediction.
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		res_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_sends.size() == 0) begin
					$error("send_type: expected none, got %0h", send_type);
					mismatches++;
				end else begin
					e = pending_sends.pop_front();
					check_field("send_type", 32'(e.send_type), 32'(send_type));
					check_field("dest_kind", 32'(e.dest_kind), 32'(dest_kind));
					check_field("dest_addr", 32'(e.dest_addr), 32'(dest_addr));
					check_field("role_now",  32'(e.role_now),  32'(role_now));
					check_field("last",      32'(e.last),      32'(last));
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic queue_evt(cmd_t c, logic [3:0] t, logic [ADDR_BITS-1:0] a, logic [9:0] r);
		evt_backlog.push_back('{c, t, a, r});
		evts_queued++;
	endtask

	// Wait until every request went through and every send came out, then let
	// the pipeline run idle before returning.
	task automatic settle();
		while (evts_done != evts_queued || pending_sends.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Setup then access cycle; the model takes the value once the write lands.
	task automatic reg_write(reg_idx_t idx, logic [CFG_BITS-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_BITS'(4 * int'(idx));
		pwdata  <= {16'($urandom), val};  // upper bits are don't-care
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_HEARTBEAT: hb_ms   = val;
			REG_LATENCY:   lat_ms  = val;
			REG_RESPONSE:  resp_ms = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(logic [CFG_BITS-1:0] hb, logic [CFG_BITS-1:0] lat,
			logic [CFG_BITS-1:0] resp);
		settle();
		reg_write(REG_HEARTBEAT, hb);
		reg_write(REG_LATENCY, lat);
		reg_write(REG_RESPONSE, resp);
	endtask

	// ------------------------------------------------------------------
	// Timeout.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL heartbeat_leader_election");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin : stimulus
		int                   counted;
		int                   pick;
		logic                 gen_run;
		cmd_t                 c;
		logic [3:0]           t;
		logic [ADDR_BITS-1:0] a;
		logic [9:0]           r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset timing (heartbeat 2000, so no timer fires).
		queue_evt(CMD_STOP,   T_NODEUP,    32'h0,         10'd0);    // stop while idle
		queue_evt(CMD_TICK,   T_MHB,       32'h0,         10'd0);    // tick while idle
		queue_evt(CMD_PACKET, T_NODEUP,    32'h1,         10'd0);    // packet while idle
		queue_evt(CMD_START,  4'd0,        32'h0,         10'd0);
		queue_evt(CMD_START,  4'd0,        32'h0,         10'd5);    // start while running
		queue_evt(CMD_PACKET, T_QUERY,     32'hFFFF_FFFF, 10'd0);
		queue_evt(CMD_PACKET, T_NODEUP,    32'h0,         10'd0);
		queue_evt(CMD_PACKET, T_CANDUP,    32'hA5A5_0001, 10'd0);    // no master heard yet
		queue_evt(CMD_PACKET, T_MHB,       32'h0000_00AA, 10'd0);
		queue_evt(CMD_PACKET, T_CANDUP,    32'h5A5A_0002, 10'd0);    // slave defends master
		queue_evt(CMD_PACKET, T_SHB,       32'hFFFF_FFFF, 10'd0);
		queue_evt(CMD_PACKET, T_SUP,       32'h1234_5678, 10'd0);
		queue_evt(CMD_PACKET, 4'd0,        32'h0,         10'd0);    // unknown types
		queue_evt(CMD_PACKET, 4'd11,       32'h0,         10'd0);
		queue_evt(CMD_PACKET, 4'd15,       32'hFFFF_FFFF, 10'd1023);
		queue_evt(CMD_PACKET, T_NODEDOWN,  32'h0,         10'd0);
		queue_evt(CMD_PACKET, T_STANDDOWN, 32'h3,         10'd0);
		queue_evt(CMD_PACKET, T_HANDOVER,  32'h4,         10'd0);    // handover makes master
		queue_evt(CMD_PACKET, T_CANDUP,    32'h5,         10'd0);
		queue_evt(CMD_PACKET, T_MHB,       32'h6,         10'd0);
		queue_evt(CMD_PACKET, T_QUERY,     32'h7,         10'd0);
		queue_evt(CMD_STOP,   4'd0,        32'h0,         10'd0);    // master hands over
		queue_evt(CMD_START,  4'd0,        32'h0,         10'd1023);
		queue_evt(CMD_PACKET, T_HANDOVER,  32'h8,         10'd0);
		queue_evt(CMD_PACKET, T_STANDDOWN, 32'h9,         10'd1023); // master steps down
		queue_evt(CMD_STOP,   4'd0,        32'h0,         10'd0);

		// Maximum timing: the wait period clips at the counter's top.
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_evt(CMD_START,  4'd0, 32'h0, 10'd1023);
		queue_evt(CMD_PACKET, T_MHB, 32'h0000_0101, 10'd0);
		for (int i = 0; i < 8; i++)
			queue_evt(CMD_TICK, 4'($urandom), $urandom, 10'($urandom));
		queue_evt(CMD_PACKET, T_HANDOVER, 32'h0000_0202, 10'd0);
		queue_evt(CMD_PACKET, T_STANDDOWN, 32'h0000_0303, 10'd1023);
		for (int i = 0; i < 8; i++)
			queue_evt(CMD_TICK, 4'($urandom), $urandom, 10'($urandom));
		queue_evt(CMD_PACKET, T_CANDUP, 32'h0000_0404, 10'd0);
		queue_evt(CMD_STOP, 4'd0, 32'h0, 10'd0);

		// Random phases: mostly running nodes with short timers so that every
		// role change happens often; a little noise while stopped.
		gen_run = 1'b0;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_timing(16'd1, 16'd0, 16'd1);
				1: set_timing(16'd0, 16'd0, 16'd0);           // zero heartbeat and response limits fire every tick
				2: set_timing(16'd2, 16'hFFFF, 16'hFFFF);
				default: set_timing(16'($urandom_range(1, 12)), 16'($urandom_range(0, 10)),
					($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
			endcase
			calm = (ph == 4);
			counted = 0;
			while (counted < 110) begin
				pick = $urandom_range(99);
				if ($urandom_range(9) == 0)
					t = 4'($urandom_range(11, 16) & 15);
				else
					t = 4'($urandom_range(1, 10));
				a = $urandom();
				if ($urandom_range(7) == 0)
					a = $urandom_range(1) ? '1 : '0;
				if ($urandom_range(9) == 0)
					r = 10'($urandom_range(1023));
				else
					r = 10'($urandom_range(7));
				if (gen_run) begin
					counted++;
					if (pick < 55)
						c = CMD_TICK;
					else if (pick < 92)
						c = CMD_PACKET;
					else if (pick < 97)
						c = CMD_START;                           // ignored while running
					else begin
						c = CMD_STOP;
						gen_run = 1'b0;
					end
				end else if (pick < 85) begin
					c = CMD_START;
					gen_run = 1'b1;
					counted++;
				end else if (pick < 90)
					c = CMD_TICK;
				else if (pick < 95)
					c = CMD_PACKET;
				else
					c = CMD_STOP;
				queue_evt(c, t, a, r);
			end
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0 && pending_sends.size() == 0) begin
			$display("PASS heartbeat_leader_election");
		end else begin
			$display("FAIL heartbeat_leader_election");
		end
		$finish;
	end

endmodule
